// ===== design/audio_channel_remix_core_defines.svh =====
// ----------------------------------------------------------------------------
// audio_channel_remix_core_defines
// Assertion macros shared by the channel remix core.
// ----------------------------------------------------------------------------
`ifndef AUDIO_CHANNEL_REMIX_CORE_DEFINES_SVH
`define AUDIO_CHANNEL_REMIX_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define ACR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define ACR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/acr_pkg.sv =====
// ----------------------------------------------------------------------------
// acr_pkg
// Types and constants of the audio channel remix core.
// ----------------------------------------------------------------------------
package acr_pkg;

  localparam int unsigned InW    = 32;
  localparam int unsigned OutW   = 16;
  localparam int unsigned CoeffW = 16;
  localparam int unsigned ChW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ChW-1:0] ChMono     = 3'd1;
  localparam logic [ChW-1:0] ChStereo   = 3'd2;
  localparam logic [ChW-1:0] ChSurround = 3'd6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSinkEnabled   = 3'd0,
    CfgSourceChannels = 3'd1,
    CfgOutputChannels = 3'd2,
    CfgCoeffFront    = 3'd3,
    CfgCoeffCenter   = 3'd4,
    CfgCoeffLfe      = 3'd5,
    CfgCoeffBack     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                     sink_enabled;
    logic [ChW-1:0]           source_channels;
    logic [ChW-1:0]           output_channels;
    logic signed [CoeffW-1:0] coeff_front;
    logic signed [CoeffW-1:0] coeff_center;
    logic signed [CoeffW-1:0] coeff_lfe;
    logic signed [CoeffW-1:0] coeff_back;
  } cfg_t;

  typedef struct packed {
    logic signed [InW-1:0] in_ch0;
    logic signed [InW-1:0] in_ch1;
    logic signed [InW-1:0] in_ch2;
    logic signed [InW-1:0] in_ch3;
    logic signed [InW-1:0] in_ch4;
    logic signed [InW-1:0] in_ch5;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] out_ch0;
    logic signed [OutW-1:0] out_ch1;
    logic signed [OutW-1:0] out_ch2;
    logic signed [OutW-1:0] out_ch3;
    logic signed [OutW-1:0] out_ch4;
    logic signed [OutW-1:0] out_ch5;
  } out_item_t;

endpackage

// ===== design/acr_cfg.sv =====
// ----------------------------------------------------------------------------
// acr_cfg
// Configuration register file: decodes register writes, holds the settings.
// ----------------------------------------------------------------------------
module acr_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [acr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [acr_pkg::CfgDataW-1:0]    cfg_data_i,
  output acr_pkg::cfg_t                   cfg_o
);

  acr_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (acr_pkg::cfg_idx_e'(cfg_index_i))
        acr_pkg::CfgSinkEnabled:    cfg_d.sink_enabled    = cfg_data_i[0];
        acr_pkg::CfgSourceChannels: cfg_d.source_channels = cfg_data_i[acr_pkg::ChW-1:0];
        acr_pkg::CfgOutputChannels: cfg_d.output_channels = cfg_data_i[acr_pkg::ChW-1:0];
        acr_pkg::CfgCoeffFront:     cfg_d.coeff_front     = $signed(cfg_data_i);
        acr_pkg::CfgCoeffCenter:    cfg_d.coeff_center    = $signed(cfg_data_i);
        acr_pkg::CfgCoeffLfe:       cfg_d.coeff_lfe       = $signed(cfg_data_i);
        acr_pkg::CfgCoeffBack:      cfg_d.coeff_back      = $signed(cfg_data_i);
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sink_enabled    <= 1'b1;
      cfg_q.source_channels <= acr_pkg::ChStereo;
      cfg_q.output_channels <= acr_pkg::ChStereo;
      cfg_q.coeff_front     <= 16'sd16384;
      cfg_q.coeff_center    <= 16'sd11585;
      cfg_q.coeff_lfe       <= 16'sd4112;
      cfg_q.coeff_back      <= 16'sd11585;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/acr_remix.sv =====
// ----------------------------------------------------------------------------
// acr_remix
// Frame datapath: clamp to 16 bits, then pass, average, spread or downmix.
// ----------------------------------------------------------------------------
module acr_remix #(
  parameter int unsigned CoeffFracBits = 14
) (
  input  acr_pkg::cfg_t      cfg_i,
  input  acr_pkg::in_item_t  item_i,
  output acr_pkg::out_item_t item_o
);

  localparam int unsigned SumW = 34;
  localparam logic signed [SumW-1:0] RoundBias =
    (SumW'(1) << CoeffFracBits) - SumW'(1);

  function automatic logic signed [acr_pkg::OutW-1:0] clamp32(
    input logic signed [acr_pkg::InW-1:0] x
  );
    logic signed [acr_pkg::OutW-1:0] r;
    if (x > 32'sd32767) begin
      r = 16'sd32767;
    end else if (x < -32'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = x[acr_pkg::OutW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [acr_pkg::OutW-1:0] sat34(
    input logic signed [SumW-1:0] x
  );
    logic signed [acr_pkg::OutW-1:0] r;
    if (x > 34'sd32767) begin
      r = 16'sd32767;
    end else if (x < -34'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = x[acr_pkg::OutW-1:0];
    end
    return r;
  endfunction

  logic signed [acr_pkg::OutW-1:0] s [6];
  logic signed [acr_pkg::OutW-1:0] o [6];
  logic signed [acr_pkg::OutW:0]   pair_sum;
  logic signed [acr_pkg::OutW:0]   pair_rnd;
  logic signed [acr_pkg::OutW-1:0] avg;
  logic signed [31:0] p_fl, p_fr, p_c, p_lfe, p_bl, p_br;
  logic signed [SumW-1:0] sum_l, sum_r, rnd_l, rnd_r, quo_l, quo_r;

  always_comb begin
    s[0] = clamp32(item_i.in_ch0);
    s[1] = clamp32(item_i.in_ch1);
    s[2] = clamp32(item_i.in_ch2);
    s[3] = clamp32(item_i.in_ch3);
    s[4] = clamp32(item_i.in_ch4);
    s[5] = clamp32(item_i.in_ch5);
  end

  always_comb begin
    pair_sum = (acr_pkg::OutW+1)'(s[0]) + (acr_pkg::OutW+1)'(s[1]);
    pair_rnd = pair_sum + (acr_pkg::OutW+1)'(pair_sum[acr_pkg::OutW]);
    avg      = acr_pkg::OutW'(pair_rnd >>> 1);
  end

  always_comb begin
    p_fl  = s[0] * cfg_i.coeff_front;
    p_fr  = s[1] * cfg_i.coeff_front;
    p_c   = s[2] * cfg_i.coeff_center;
    p_lfe = s[3] * cfg_i.coeff_lfe;
    p_bl  = s[4] * cfg_i.coeff_back;
    p_br  = s[5] * cfg_i.coeff_back;
    sum_l = SumW'(p_fl) + SumW'(p_c) + SumW'(p_lfe) + SumW'(p_bl);
    sum_r = SumW'(p_fr) + SumW'(p_c) + SumW'(p_lfe) + SumW'(p_br);
    rnd_l = sum_l + (sum_l[SumW-1] ? RoundBias : '0);
    rnd_r = sum_r + (sum_r[SumW-1] ? RoundBias : '0);
    quo_l = rnd_l >>> CoeffFracBits;
    quo_r = rnd_r >>> CoeffFracBits;
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      o[i] = '0;
    end
    if (cfg_i.sink_enabled) begin
      case (cfg_i.source_channels)
        acr_pkg::ChMono: begin
          if (cfg_i.output_channels >= 3'd1 && cfg_i.output_channels <= 3'd6) begin
            for (int i = 0; i < 6; i++) begin
              o[i] = (3'(i) < cfg_i.output_channels) ? s[0] : '0;
            end
            if (cfg_i.output_channels == acr_pkg::ChSurround) begin
              o[3] = '0;
            end
          end
        end
        acr_pkg::ChStereo: begin
          case (cfg_i.output_channels)
            acr_pkg::ChMono: o[0] = avg;
            acr_pkg::ChStereo: begin
              o[0] = s[0];
              o[1] = s[1];
            end
            acr_pkg::ChSurround: begin
              o[0] = s[0];
              o[1] = s[1];
              o[2] = avg;
              o[4] = s[0];
              o[5] = s[1];
            end
            default: ;
          endcase
        end
        acr_pkg::ChSurround: begin
          case (cfg_i.output_channels)
            acr_pkg::ChMono: o[0] = avg;
            acr_pkg::ChStereo: begin
              o[0] = sat34(quo_l);
              o[1] = sat34(quo_r);
            end
            acr_pkg::ChSurround: begin
              for (int i = 0; i < 6; i++) begin
                o[i] = s[i];
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign item_o.out_ch0 = o[0];
  assign item_o.out_ch1 = o[1];
  assign item_o.out_ch2 = o[2];
  assign item_o.out_ch3 = o[3];
  assign item_o.out_ch4 = o[4];
  assign item_o.out_ch5 = o[5];

endmodule

// ===== design/audio_channel_remix_core.sv =====
// ----------------------------------------------------------------------------
// audio_channel_remix_core
// Channel remixer: clamps a six-sample frame to 16 bits and maps it from the
// configured source channel count to the configured output channel count.
//
//   channel | handshake           | beat
//   --------+---------------------+-------------------------------
//   in      | in_valid_i/in_stall_o   | in_item_i, one mix frame
//   out     | out_valid_o/out_stall_i | out_item_o, one output frame
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat per cycle sustained while out_stall_i is low; a beat passes from the
// input register to the result register through one pass of the remix datapath.
// Reset clears the stage valid bits and loads the register defaults.
// An output stall holds the result; the input register still takes one
// more beat, and in_stall_o rises only while both stages are full.
// ----------------------------------------------------------------------------
`include "audio_channel_remix_core_defines.svh"

module audio_channel_remix_core #(
  parameter int unsigned CoeffFracBits = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  acr_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output acr_pkg::out_item_t           out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [acr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [acr_pkg::CfgDataW-1:0] cfg_data_i
);

  acr_pkg::cfg_t      cfg;
  acr_pkg::in_item_t  in_item_q;
  acr_pkg::out_item_t mix_item;
  acr_pkg::out_item_t out_item_q;
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_hold;
  logic advance;
  logic in_take;

  assign cfg_ready_o = 1'b1;

  acr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  acr_remix #(
    .CoeffFracBits (CoeffFracBits)
  ) u_remix (
    .cfg_i  (cfg),
    .item_i (in_item_q),
    .item_o (mix_item)
  );

  assign out_hold   = out_valid_q & out_stall_i;
  assign advance    = in_valid_q & ~out_hold;
  assign in_stall_o = in_valid_q & out_hold;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_comb begin
    in_valid_d  = in_take | (in_valid_q & out_hold);
    out_valid_d = advance | out_hold;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= mix_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ACR_ASSERT_NEXT(a_take_fills, in_valid_i && !in_stall_o, in_valid_q,
    "accepted beat did not reach the input register")
  `ACR_ASSERT_NEXT(a_advance_fills, in_valid_q && !out_hold, out_valid_o,
    "advanced beat did not reach the result register")
  `ACR_ASSERT_SAME(a_empty_open, !in_valid_q || !out_valid_o, !in_stall_o,
    "input stalled with a free stage")

endmodule
